>>> rtl/core/mbps_pkg.sv
package mbps_pkg;

  // fixed field and register widths
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned PatternRegs  = 4;
  localparam int unsigned PatternBytes = 32;
  localparam int unsigned PatIdxW      = 5;
  localparam int unsigned LenRawW      = 6;
  localparam int unsigned WildW        = 32;
  localparam int unsigned AddrW        = 32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPattern0 = 3'd0,
    CfgPattern1 = 3'd1,
    CfgPattern2 = 3'd2,
    CfgPattern3 = 3'd3,
    CfgWildcard = 3'd4,
    CfgLength   = 3'd5,
    CfgBase     = 3'd6
  } cfg_index_e;

  // one input byte of the region
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // one search report
  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
    logic [AddrW-1:0] match_offset;
  } out_item_t;

  // report from the match stage towards the result register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } match_res_t;

endpackage

>>> rtl/core/mbps_cfg_regs.sv
module mbps_cfg_regs import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  localparam int unsigned LenW = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CfgIdxW-1:0]                  cfg_index_i,
  input  logic [CfgDataW-1:0]                 cfg_data_i,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]   aligned_o,
  output logic [MAX_PATTERN_BYTES-1:0]        care_o,
  output logic [LenW-1:0]                     len_o,
  output logic [AddrW-1:0]                    base_o
);

  logic [PatternRegs-1:0][CfgDataW-1:0] pat_q;
  logic [WildW-1:0]                     wild_q;
  logic [LenRawW-1:0]                   len_raw_q;
  logic [AddrW-1:0]                     base_q;

  logic [PatternBytes-1:0][7:0]         pat_bytes;
  logic [LenRawW-1:0]                   len_eff;
  logic [MAX_PATTERN_BYTES-1:0][7:0]    aligned_d, aligned_q;
  logic [MAX_PATTERN_BYTES-1:0]         care_d, care_q;
  logic [LenW-1:0]                      len_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      wild_q    <= '0;
      len_raw_q <= LenRawW'(1);
      base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgPattern0: pat_q[0]  <= cfg_data_i;
        CfgPattern1: pat_q[1]  <= cfg_data_i;
        CfgPattern2: pat_q[2]  <= cfg_data_i;
        CfgPattern3: pat_q[3]  <= cfg_data_i;
        CfgWildcard: wild_q    <= cfg_data_i[WildW-1:0];
        CfgLength:   len_raw_q <= cfg_data_i[LenRawW-1:0];
        CfgBase:     base_q    <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_q;

  // clamp the pattern length into 1 .. max
  always_comb begin
    if (len_raw_q == '0) begin
      len_eff = LenRawW'(1);
    end else if (len_raw_q > LenRawW'(MAX_PATTERN_BYTES)) begin
      len_eff = LenRawW'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = len_raw_q;
    end
  end

  // pattern reversed onto window positions, newest byte at position 0
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_align
    logic [LenRawW-1:0] idx;
    assign idx          = len_eff - LenRawW'(j) - LenRawW'(1);
    assign aligned_d[j] = pat_bytes[idx[PatIdxW-1:0]];
    assign care_d[j]    = (LenRawW'(j) < len_eff) && !wild_q[idx[PatIdxW-1:0]];
  end

  // derived pattern view, registered from the configuration registers
  always_ff @(posedge clk_i) begin
    aligned_q <= aligned_d;
    care_q    <= care_d;
    len_q     <= LenW'(len_eff);
  end

  assign aligned_o = aligned_q;
  assign care_o    = care_q;
  assign len_o     = len_q;
  assign base_o    = base_q;

endmodule

>>> rtl/core/mbps_match.sv
module mbps_match import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned ADDRESS_BITS      = 32,
  localparam int unsigned LenW = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  in_item_t                          item_i,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0] aligned_i,
  input  logic [MAX_PATTERN_BYTES-1:0]      care_i,
  input  logic [LenW-1:0]                   len_i,
  input  logic [AddrW-1:0]                  base_i,
  output match_res_t                        res_o
);

  localparam logic [AddrW-1:0] AddrMask = (ADDRESS_BITS >= AddrW) ? '1 :
      AddrW'((65'd1 << ADDRESS_BITS) - 65'd1);

  logic [MAX_PATTERN_BYTES-1:0][7:0] win_q, win_d;
  logic [AddrW-1:0]                  seen_q, seen_nx;
  logic                              reported_q;
  logic [MAX_PATTERN_BYTES-1:0]      pos_ok;
  logic                              hit;
  logic [AddrW-1:0]                  offset;
  logic [AddrW-1:0]                  address;

  // window shifted by the incoming byte
  assign win_d[0] = item_i.data_byte;
  for (genvar j = 1; j < MAX_PATTERN_BYTES; j++) begin : g_shift
    assign win_d[j] = win_q[j-1];
  end

  // per-position compare, wildcard and unused positions always pass
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cmp
    assign pos_ok[j] = !care_i[j] || (win_d[j] == aligned_i[j]);
  end

  // saturating byte count and report fields
  assign seen_nx = (seen_q == '1) ? seen_q : seen_q + AddrW'(1);
  assign hit     = (base_i != '0) && (seen_nx >= AddrW'(len_i)) && (&pos_ok);
  assign offset  = seen_nx - AddrW'(len_i);
  assign address = (base_i + offset) & AddrMask;

  always_comb begin
    res_o.valid              = fire_i && !reported_q && (hit || item_i.last_byte);
    res_o.item.found         = hit;
    res_o.item.match_address = hit ? address : '0;
    res_o.item.match_offset  = hit ? offset : '0;
  end

  // region state, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else if (!reported_q) begin
        seen_q <= seen_nx;
        if (hit) begin
          reported_q <= 1'b1;
        end
      end
    end
  end

  // window bytes are only compared once written in the current region
  always_ff @(posedge clk_i) begin
    if (fire_i && !reported_q) begin
      win_q <= win_d;
    end
  end

endmodule

>>> rtl/core/masked_byte_pattern_search_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid_i / in_stall_o    in_item_i (data_byte, last_byte)
// out      output     out_valid_o / out_stall_i  out_item_o (found, address, offset)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one byte accepted per cycle while in_stall_o is low; a report is offered from the result register
// the input register feeds the window compare, which loads the result register
// cfg_ready_o is always high; pattern changes pass the config registers, then the derived pattern registers
// reset clears the region state, the valid flags and the config registers, pattern length resets to one
// a held result blocks the input only once the input register is also full
module masked_byte_pattern_search_unit import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned ADDRESS_BITS      = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN_BYTES + 1);

  logic                              s1_valid_q;
  in_item_t                          s1_item_q;
  logic                              res_valid_q;
  out_item_t                         res_item_q;
  logic                              out_ready;
  logic                              s1_fire;
  logic                              in_xfer;
  logic [MAX_PATTERN_BYTES-1:0][7:0] aligned;
  logic [MAX_PATTERN_BYTES-1:0]      care;
  logic [LenW-1:0]                   len;
  logic [AddrW-1:0]                  base;
  match_res_t                        match_res;

  assign cfg_ready_o = 1'b1;

  mbps_cfg_regs #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .aligned_o  (aligned),
    .care_o     (care),
    .len_o      (len),
    .base_o     (base)
  );

  // pipeline handshake
  assign out_ready  = !res_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
  end

  mbps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .ADDRESS_BITS     (ADDRESS_BITS)
  ) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .item_i   (s1_item_q),
    .aligned_i(aligned),
    .care_i   (care),
    .len_i    (len),
    .base_i   (base),
    .res_o    (match_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_ready) begin
      res_valid_q <= match_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && match_res.valid) begin
      res_item_q <= match_res.item;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_item_q;

  // input is only held back by a full pipe behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a stalled result");

  // a not-found report carries zero address and offset
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.found) |->
      (out_item_o.match_address == '0 && out_item_o.match_offset == '0))
    else $error("not-found report with nonzero fields");

  // a zero base address never yields a match
  a_zero_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_res.valid && match_res.item.found) |-> (base != '0))
    else $error("match reported with zero base address");

endmodule

>>> sim/tb_masked_byte_pattern_search_unit.sv
module tb_masked_byte_pattern_search_unit;
  import mbps_pkg::*;

  // run shape
  localparam int unsigned ScanTarget  = 1200;
  localparam int unsigned PhaseBytes  = 100;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned LimitCycles = 400000;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  typedef enum logic [1:0] {
    StallNever,
    StallLight,
    StallHeavy,
    StallAlternate
  } stall_mode_e;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  masked_byte_pattern_search_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the search registers
  logic [CfgDataW-1:0] sig_regs [PatternRegs];
  logic [WildW-1:0]    sig_wild;
  logic [LenRawW-1:0]  sig_len_raw;
  logic [AddrW-1:0]    sig_base;

  // shadow region state
  logic [7:0]  window [PatternBytes];
  logic [31:0] seen_count;
  logic        region_done;

  in_item_t    pending_bytes [$];
  out_item_t   expected_reports [$];
  reg_write_t  reg_writes [$];

  int unsigned queued_count  = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  logic        hold_token    = 1'b0;

  initial begin
    for (int r = 0; r < PatternRegs; r++) sig_regs[r] = '0;
    sig_wild    = '0;
    sig_len_raw = 6'd1;
    sig_base    = '0;
    window      = '{default: '0};
    seen_count  = '0;
    region_done = 1'b0;
  end

  function automatic int unsigned active_length(input logic [LenRawW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > PatternBytes) return PatternBytes;
    return raw;
  endfunction

  function automatic logic [7:0] sig_byte(input int unsigned i);
    return sig_regs[(i % PatternBytes) / 8][(i % 8) * 8 +: 8];
  endfunction

  // register write as the block should see it
  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CfgPattern0: sig_regs[0] = data;
      CfgPattern1: sig_regs[1] = data;
      CfgPattern2: sig_regs[2] = data;
      CfgPattern3: sig_regs[3] = data;
      CfgWildcard: sig_wild = data[WildW-1:0];
      CfgLength:   sig_len_raw = data[LenRawW-1:0];
      CfgBase:     sig_base = data[AddrW-1:0];
      default: ;
    endcase
  endtask

  // window update and match test for one accepted byte
  task automatic scan_byte(input in_item_t it);
    int unsigned n;
    logic        hit;
    out_item_t   rep;
    if (!region_done) begin
      n = active_length(sig_len_raw);
      for (int k = PatternBytes - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = it.data_byte;
      if (seen_count != '1) seen_count++;
      hit = (sig_base != 0) && (seen_count >= n);
      for (int i = 0; i < n; i++) begin
        if (!sig_wild[i] && sig_byte(i) != window[n-1-i]) hit = 1'b0;
      end
      if (hit) begin
        rep.found         = 1'b1;
        rep.match_offset  = seen_count - n;
        rep.match_address = sig_base + rep.match_offset;
        region_done       = 1'b1;
        expected_reports.insert(expected_reports.size(), rep);
      end else if (it.last_byte) begin
        rep = '0;
        expected_reports.insert(expected_reports.size(), rep);
      end
    end
    if (it.last_byte) begin
      window      = '{default: '0};
      seen_count  = '0;
      region_done = 1'b0;
    end
  endtask

  function automatic logic [CfgDataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // zero, all ones or random
  function automatic logic [CfgDataW-1:0] pick64();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rand64();
  endfunction

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    reg_write_t w;
    w.index = idx;
    w.data  = data;
    reg_writes.insert(reg_writes.size(), w);
  endtask

  // back-to-back register transfers, valid held across the list
  task automatic write_regs();
    int unsigned n;
    n = 0;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_writes[0].index;
    cfg_data_i  <= reg_writes[0].data;
    while (n < reg_writes.size()) begin
      @(posedge clk_i);
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(reg_writes[n].index, reg_writes[n].data);
        n++;
        if (n < reg_writes.size()) begin
          cfg_index_i <= reg_writes[n].index;
          cfg_data_i  <= reg_writes[n].data;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
    reg_writes = {};
  endtask

  task automatic queue_item(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    pending_bytes.insert(pending_bytes.size(), it);
    queued_count++;
  endtask

  // wait for every byte and report, then let trailing bytes drain
  task automatic wait_idle();
    while (accepted_count != queued_count || expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one region: planted pattern, spoilt pattern or noise
  task automatic queue_region(output int unsigned count);
    logic [7:0]  bytes [$];
    int unsigned n;
    int unsigned style;
    int unsigned j;
    n     = active_length(sig_len_raw);
    style = $urandom_range(0, 9);
    repeat ($urandom_range(0, 6)) bytes.insert(bytes.size(), 8'($urandom));
    if (style <= 7) begin
      for (int i = 0; i < n; i++)
        bytes.insert(bytes.size(), sig_wild[i] ? 8'($urandom) : sig_byte(i));
      if (style == 7) begin
        j = $urandom_range(0, n - 1);
        bytes[bytes.size() - n + j] ^= 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 4)) bytes.insert(bytes.size(), 8'($urandom));
    end else begin
      repeat ($urandom_range(1, n + 8)) bytes.insert(bytes.size(), 8'($urandom));
    end
    for (int i = 0; i < bytes.size(); i++) queue_item(bytes[i], i == bytes.size() - 1);
    count = bytes.size();
  endtask

  // phase settings, extremes on the early phases
  task automatic program_phase(input int unsigned p, input logic squeeze);
    logic [CfgDataW-1:0] len_word;
    logic [CfgDataW-1:0] wild_word;
    logic [CfgDataW-1:0] base_word;
    int unsigned         r;
    len_word  = rand64();
    wild_word = rand64();
    base_word = rand64();
    r = $urandom_range(0, 9);
    if (r == 0) len_word[LenRawW-1:0] = 6'd1;
    else if (r == 1) len_word[LenRawW-1:0] = 6'd32;
    else if (r == 2) len_word[LenRawW-1:0] = 6'd0;
    else if (r == 3) len_word[LenRawW-1:0] = 6'($urandom_range(33, 63));
    else len_word[LenRawW-1:0] = 6'($urandom_range(1, 8));
    r = $urandom_range(0, 5);
    if (r == 0) wild_word[WildW-1:0] = '0;
    else if (r == 1) wild_word[WildW-1:0] = $urandom & $urandom;
    r = $urandom_range(0, 7);
    if (r == 0) base_word[AddrW-1:0] = '0;
    else if (r == 1) base_word[AddrW-1:0] = '1;
    case (p)
      0: begin
        len_word[LenRawW-1:0] = 6'd32;
        wild_word[WildW-1:0]  = '0;
      end
      1: begin
        len_word[LenRawW-1:0]  = 6'd1;
        base_word[AddrW-1:0]   = '1;
      end
      2: begin
        len_word[LenRawW-1:0] = 6'd63;
        wild_word[WildW-1:0]  = '1;
      end
      4: base_word[AddrW-1:0] = '0;
      5: len_word[LenRawW-1:0] = 6'd0;
      default: ;
    endcase
    // short regions that each report at once
    if (squeeze) begin
      len_word[LenRawW-1:0] = 6'd1;
      wild_word[WildW-1:0]  = '1;
      base_word[AddrW-1:0]  = $urandom | 32'd1;
    end
    add_write(CfgPattern0, pick64());
    add_write(CfgPattern1, pick64());
    add_write(CfgPattern2, pick64());
    add_write(CfgPattern3, pick64());
    add_write(CfgWildcard, wild_word);
    add_write(CfgLength, len_word);
    add_write(CfgBase, base_word);
    write_regs();
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i) begin : drive_bytes
    logic     offer;
    in_item_t next_item;
    offer     = in_valid_i;
    next_item = in_item_i;
    if (in_valid_i && !in_stall_o) begin
      scan_byte(in_item_i);
      accepted_count++;
      offer = 1'b0;
    end
    if (!offer && rst_ni) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_bytes.size() != 0) begin
        next_item = pending_bytes.pop_front();
        offer     = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid_i <= offer;
    in_item_i  <= next_item;
  end

  // receiver: stall pattern of its own plus a long hold-off on request
  stall_mode_e stall_mode = StallNever;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  logic        hold_seen  = 1'b0;
  logic        alt_phase  = 1'b0;

  always @(posedge clk_i) begin : drive_stall
    logic stall_next;
    stall_next = 1'b0;
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      stall_next = 1'b1;
    end else if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HoldCycles;
      stall_next = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        StallNever:     stall_next = 1'b0;
        StallLight:     stall_next = ($urandom_range(0, 3) == 0);
        StallHeavy:     stall_next = ($urandom_range(0, 3) != 0);
        StallAlternate: stall_next = alt_phase;
        default:        stall_next = 1'b0;
      endcase
      alt_phase <= ~alt_phase;
    end
    out_stall_i <= stall_next;
  end

  // compare each report transfer with the oldest expectation
  always @(posedge clk_i) begin : check_reports
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual found=%0b address=%h offset=%h",
                 $time, out_item_o.found, out_item_o.match_address, out_item_o.match_offset);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_item_o.found !== want.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, want.found, out_item_o.found);
          error_count++;
        end
        if (out_item_o.match_address !== want.match_address) begin
          $display("%0t: match_address mismatch: expected %h, actual %h",
                   $time, want.match_address, out_item_o.match_address);
          error_count++;
        end
        if (out_item_o.match_offset !== want.match_offset) begin
          $display("%0t: match_offset mismatch: expected %h, actual %h",
                   $time, want.match_offset, out_item_o.match_offset);
          error_count++;
        end
      end
    end
  end

  initial begin : run_scan
    int unsigned p;
    int unsigned made;
    int unsigned region_len;
    logic        squeeze;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero base, so not found
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b1);
    wait_idle();

    // four-byte pattern, byte one wildcard, base address near the top
    add_write(CfgPattern0, {$urandom, 32'hEFBE_ADDE});
    add_write(CfgPattern1, rand64());
    add_write(CfgPattern2, rand64());
    add_write(CfgPattern3, rand64());
    add_write(CfgWildcard, {32'hFFFF_FFFF, 32'h0000_0002});
    add_write(CfgLength, {58'h0, 6'd4});
    add_write(CfgBase, {32'h0, 32'hFFFF_FFF0});
    add_write(CfgSpare, rand64());
    write_regs();
    // match mid-region, then ignored bytes up to the end
    queue_item(8'h11, 1'b0);
    queue_item(8'hDE, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'hBE, 1'b0);
    queue_item(8'hEF, 1'b0);
    queue_item(8'h55, 1'b0);
    queue_item(8'hAA, 1'b1);
    // region shorter than the pattern
    queue_item(8'hDE, 1'b0);
    queue_item(8'hAD, 1'b1);
    // near miss on the last byte
    queue_item(8'hDE, 1'b0);
    queue_item(8'hAD, 1'b0);
    queue_item(8'hBE, 1'b0);
    queue_item(8'h00, 1'b1);
    // single-byte region
    queue_item(8'h77, 1'b1);
    wait_idle();

    // length zero acts as one; match on the final byte, address wraps to zero
    add_write(CfgPattern0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(CfgWildcard, 64'h0);
    add_write(CfgLength, 64'hFFFF_FFFF_FFFF_FFC0);
    add_write(CfgBase, 64'h0000_0000_FFFF_FFFF);
    write_regs();
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b1);
    wait_idle();

    // length above the maximum acts as the maximum
    add_write(CfgLength, {58'h0, 6'd63});
    write_regs();
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b1);
    wait_idle();

    // random phases, every fourth one with a long receiver hold-off
    p = 0;
    while (queued_count < ScanTarget) begin
      squeeze = (p % 4 == 3);
      program_phase(p, squeeze);
      made = 0;
      if (squeeze) begin
        @(posedge clk_i);
        hold_token <= ~hold_token;
        while (made < PhaseBytes) begin
          region_len = $urandom_range(1, 3);
          for (int i = 0; i < region_len; i++)
            queue_item(8'($urandom), i == region_len - 1);
          made += region_len;
        end
      end else begin
        while (made < PhaseBytes) begin
          queue_region(region_len);
          made += region_len;
        end
      end
      wait_idle();
      p++;
    end

    if (error_count == 0) begin
      $display("tb_masked_byte_pattern_search_unit: done, clean");
    end else begin
      $display("tb_masked_byte_pattern_search_unit: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitCycles * 4);
    $display("tb_masked_byte_pattern_search_unit: done, errors");
    $finish;
  end

endmodule

>>> masked_byte_pattern_search_unit.f
rtl/core/mbps_pkg.sv
rtl/core/mbps_cfg_regs.sv
rtl/core/mbps_match.sv
rtl/core/masked_byte_pattern_search_unit.sv
sim/tb_masked_byte_pattern_search_unit.sv
